// ----- design/spf_pkg.sv -----
// Shared types and constants for the serial packet framer.
// No dependencies; used by every module of the block by scoped names.
package spf_pkg;

  // Default largest payload length; longer requests saturate to it
  localparam int MAX_PAYLOAD_DEF = 32;

  // Most bytes a single item can produce: start, command, length,
  // one payload byte and an escaped two-byte checksum
  localparam int BURST_MAX = 6;
  localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);
  localparam int BURST_IDX_W = $clog2(BURST_MAX);

  // Byte kind codes on the result channel
  localparam logic [2:0] KIND_START    = 3'd0;
  localparam logic [2:0] KIND_COMMAND  = 3'd1;
  localparam logic [2:0] KIND_LENGTH   = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd3;
  localparam logic [2:0] KIND_CHECKSUM = 3'd4;

  // Checksum escape: an escaped value goes out as ESC_LEAD then a code byte
  localparam logic [7:0] ESC_LEAD      = 8'hfd;
  localparam logic [7:0] ESC_FF_CODE   = 8'hfe;
  localparam logic [7:0] ESC_FD_CODE   = 8'hfc;
  localparam logic [7:0] CHK_SEED      = 8'hff;
  localparam logic [7:0] START_DEF     = 8'hff;

  typedef struct packed {
    logic [7:0] command;
    logic [5:0] payload_length;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] byte_kind;
    logic       is_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] byte_kind;
  } burst_ent_t;

  // All bytes one item produces, entry 0 goes out first
  typedef struct packed {
    burst_ent_t [BURST_MAX-1:0] ent;
    logic [BURST_CNT_W-1:0]     cnt;
  } burst_t;

endpackage

// ----- design/serial_packet_framer_core.sv -----
// Top level of the serial packet framer: configuration register, framer
// and emitter. Depends on spf_pkg, spf_framer and spf_emitter.
//
// Usage:
//   Input channel (in_valid/in_ready/in_item) takes one item per packet
//   byte group: the first item of a packet carries command, length and the
//   first payload byte; each later item carries one payload byte.
//   Result channel (out_valid/out_ready/out_item) gives framed bytes one per
//   cycle while out_ready is high: start, command, length, payload, checksum
//   (0xff, 0xfd escaped as two bytes). is_last marks each item's last byte.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes the start byte;
//   cfg_ready is always high. Write only while the block is idle.
// Timing:
//   An item's first byte passes through the burst buffer and then the
//   output register before it appears on out_item. Mid-packet payload
//   items that leave the packet open flow at one per cycle while out_ready is
//   high; the rate is set by the single byte-wide output register.
// Reset: start byte returns to 0xff, no packet is open, outputs go idle.
// Stall: when out_ready is low the output byte and the buffered burst hold,
//   and in_ready drops once the burst buffer cannot free up.
module serial_packet_framer_core #(
  parameter int MAX_PAYLOAD = spf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output spf_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  logic [7:0]      start_byte_r;
  spf_pkg::burst_t burst;
  logic            burst_ready;
  logic            accept;

  // Start byte register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= spf_pkg::START_DEF;
    end else if (cfg_valid && cfg_ready) begin
      start_byte_r <= cfg_data;
    end
  end

  assign in_ready = burst_ready;
  assign accept   = in_valid && burst_ready;

  spf_framer #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (in_item),
    .accept     (accept),
    .start_byte (start_byte_r),
    .burst      (burst)
  );

  spf_emitter u_emitter (
    .clk         (clk),
    .rst_n       (rst_n),
    .burst       (burst),
    .burst_valid (in_valid),
    .burst_ready (burst_ready),
    .out_item    (out_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

endmodule

// ----- design/spf_framer.sv -----
// Packet framing logic: holds the packet state and turns one input item
// into its burst of framed bytes. Depends on spf_pkg.
module spf_framer #(
  parameter int MAX_PAYLOAD = spf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  spf_pkg::in_item_t item,
  input  logic              accept,
  input  logic [7:0]        start_byte,
  output spf_pkg::burst_t   burst
);

  localparam logic [5:0] MAX_LEN = 6'(MAX_PAYLOAD);

  logic [5:0]                     rem_r, rem_nxt;
  logic [7:0]                     sum_r, sum_nxt;
  logic                           inp_r, inp_nxt;
  logic [5:0]                     len_sat;
  logic [7:0]                     sum_hdr;
  logic [7:0]                     chk;
  logic                           close;
  logic                           esc;
  logic [spf_pkg::BURST_IDX_W-1:0] pos;
  logic [7:0]                     chk_b0, chk_b1;

  // Build the burst and the next packet state
  always_comb begin
    burst   = '0;
    rem_nxt = rem_r;
    sum_nxt = sum_r;
    close   = 1'b0;
    pos     = '0;
    len_sat = (item.payload_length > MAX_LEN) ? MAX_LEN : item.payload_length;
    sum_hdr = spf_pkg::CHK_SEED + item.command + {2'b00, len_sat};

    if (inp_r && (rem_r != 6'd0)) begin
      // Mid-packet: one payload byte
      burst.ent[0] = '{out_byte: item.data_byte, byte_kind: spf_pkg::KIND_PAYLOAD};
      sum_nxt = sum_r + item.data_byte;
      rem_nxt = rem_r - 6'd1;
      pos     = spf_pkg::BURST_IDX_W'(1);
      close   = (rem_nxt == 6'd0);
    end else begin
      // Packet header
      burst.ent[0] = '{out_byte: start_byte,      byte_kind: spf_pkg::KIND_START};
      burst.ent[1] = '{out_byte: item.command,    byte_kind: spf_pkg::KIND_COMMAND};
      burst.ent[2] = '{out_byte: {2'b00, len_sat}, byte_kind: spf_pkg::KIND_LENGTH};
      if (len_sat == 6'd0) begin
        sum_nxt = sum_hdr;
        rem_nxt = 6'd0;
        pos     = spf_pkg::BURST_IDX_W'(3);
        close   = 1'b1;
      end else begin
        burst.ent[3] = '{out_byte: item.data_byte, byte_kind: spf_pkg::KIND_PAYLOAD};
        sum_nxt = sum_hdr + item.data_byte;
        rem_nxt = len_sat - 6'd1;
        pos     = spf_pkg::BURST_IDX_W'(4);
        close   = (rem_nxt == 6'd0);
      end
    end

    // Checksum with escape of the two reserved values
    chk    = 8'h00 - sum_nxt;
    esc    = (chk == 8'hff) || (chk == spf_pkg::ESC_LEAD);
    chk_b0 = esc ? spf_pkg::ESC_LEAD : chk;
    chk_b1 = (chk == 8'hff) ? spf_pkg::ESC_FF_CODE : spf_pkg::ESC_FD_CODE;

    burst.cnt = spf_pkg::BURST_CNT_W'(pos);
    if (close) begin
      burst.ent[pos] = '{out_byte: chk_b0, byte_kind: spf_pkg::KIND_CHECKSUM};
      burst.cnt      = spf_pkg::BURST_CNT_W'(pos) + spf_pkg::BURST_CNT_W'(1);
      if (esc) begin
        burst.ent[spf_pkg::BURST_IDX_W'(pos + 1'b1)] =
          '{out_byte: chk_b1, byte_kind: spf_pkg::KIND_CHECKSUM};
        burst.cnt = spf_pkg::BURST_CNT_W'(pos) + spf_pkg::BURST_CNT_W'(2);
      end
    end
    inp_nxt = (rem_nxt != 6'd0);
  end

  // Advance packet state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      sum_r <= '0;
      inp_r <= 1'b0;
    end else if (accept) begin
      rem_r <= rem_nxt;
      sum_r <= sum_nxt;
      inp_r <= inp_nxt;
    end
  end

  // Open packet always expects at least one more byte
  a_open_has_rem: assert property (@(posedge clk) disable iff (!rst_n)
    inp_r |-> (rem_r != 6'd0))
    else $error("open packet with no bytes remaining");

  // Remaining count never exceeds the length limit
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r < MAX_LEN || rem_r == MAX_LEN)
    else $error("remaining count above limit");

  // A burst always carries at least one byte and ends a packet with a checksum
  a_close_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !inp_nxt) |-> burst.cnt != '0 &&
      burst.ent[spf_pkg::BURST_IDX_W'(burst.cnt - 1'b1)].byte_kind ==
      spf_pkg::KIND_CHECKSUM)
    else $error("closing burst lacks checksum");

endmodule

// ----- design/spf_emitter.sv -----
// Burst buffer and output register: holds one item's bytes and sends them on
// the result channel one per cycle while out_ready is high. Depends on spf_pkg.
module spf_emitter (
  input  logic               clk,
  input  logic               rst_n,
  input  spf_pkg::burst_t    burst,
  input  logic               burst_valid,
  output logic               burst_ready,
  output spf_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_ready
);

  spf_pkg::burst_t                  buf_r;
  logic [spf_pkg::BURST_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [spf_pkg::BURST_IDX_W-1:0]  idx_r, idx_nxt;
  spf_pkg::out_item_t               out_r;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_free;
  logic                             move;
  logic                             load;

  // Move a byte when the output register is empty or being taken
  assign out_free    = !out_valid_r || out_ready;
  assign move        = (cnt_r != '0) && out_free;
  assign burst_ready = (cnt_r == '0) ||
                       ((cnt_r == spf_pkg::BURST_CNT_W'(1)) && out_free);
  assign load        = burst_valid && burst_ready;

  always_comb begin
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (move) begin
      cnt_nxt       = cnt_r - spf_pkg::BURST_CNT_W'(1);
      idx_nxt       = idx_r + spf_pkg::BURST_IDX_W'(1);
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      cnt_nxt = burst.cnt;
      idx_nxt = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: hold burst and output byte
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= burst;
    end
    if (move) begin
      out_r.out_byte  <= buf_r.ent[idx_r].out_byte;
      out_r.byte_kind <= buf_r.ent[idx_r].byte_kind;
      out_r.is_last   <= (cnt_r == spf_pkg::BURST_CNT_W'(1));
    end
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

  // Never more bytes pending than a burst can hold
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, idx_r} + {1'b0, cnt_r}) <= (spf_pkg::BURST_CNT_W + 1)'(spf_pkg::BURST_MAX))
    else $error("burst index past end");

  // A loaded burst is never empty
  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (burst.cnt != '0))
    else $error("empty burst loaded");

  // The final byte of a burst is marked last
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (move && cnt_r == spf_pkg::BURST_CNT_W'(1)) |=> (out_valid_r && out_r.is_last))
    else $error("last byte not marked");

endmodule
